>>> sv/bdrd_pkg.sv
// Shared types, constants and calendar tables for the business day return date block.
// No dependencies; imported by every module of the block.
package bdrd_pkg;

  localparam int COUNT_BITS_DEF = 12;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 14;
  localparam int BDAYS_W = 12;
  localparam int WD_W    = 3;
  localparam int YREM_W  = 7;
  localparam int YCENT_W = 8;
  localparam int DIVR_W  = 15;
  localparam int TRIAL_W = 18;

  localparam logic [YEAR_W-1:0]  YEAR_MAX    = YEAR_W'(9999);
  localparam logic [MONTH_W-1:0] MONTH_FEB   = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC   = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAY_LAST    = DAY_W'(31);
  localparam logic [WD_W-1:0]    WD_FRI      = WD_W'(5);
  localparam logic [WD_W-1:0]    WD_SAT      = WD_W'(6);
  localparam logic [YREM_W-1:0]  YEARS_CENT  = YREM_W'(100);
  localparam int                 DIV_YEAR    = 100;
  localparam int                 DIV_WEEK    = 7;
  localparam logic [3:0]         DIV_TOP     = 4'd7;
  localparam logic [3:0]         MOD_TOP     = 4'd12;

  typedef struct packed {
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [BDAYS_W-1:0] business_days;
  } in_req_t;

  typedef struct packed {
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               year_overflow;
  } out_rsp_t;

  // Current date plus the year split into year-within-century and century.
  typedef struct packed {
    logic [DAY_W-1:0]   day;
    logic [MONTH_W-1:0] month;
    logic [YEAR_W-1:0]  year;
    logic [WD_W-1:0]    wd;
    logic [YREM_W-1:0]  yrem;
    logic [YCENT_W-1:0] ycent;
  } date_st_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_MOD,
    ST_SKIP1,
    ST_COUNT,
    ST_SKIP2,
    ST_FINISH
  } bdrd_state_t;

  // Length of a month; months outside 1..12 count as 31 days.
  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
    logic [DAY_W-1:0] d;
    unique case (m)
      4'd2:    d = leap ? DAY_W'(29) : DAY_W'(28);
      4'd4:    d = DAY_W'(30);
      4'd6:    d = DAY_W'(30);
      4'd9:    d = DAY_W'(30);
      4'd11:   d = DAY_W'(30);
      default: d = DAY_W'(31);
    endcase
    return d;
  endfunction

  // Month term (31 * shifted month) / 12 of the weekday formula, by input month.
  function automatic logic [5:0] mo_term(input logic [MONTH_W-1:0] m);
    logic [5:0] t;
    unique case (m)
      4'd0:  t = 6'd25;
      4'd1:  t = 6'd28;
      4'd2:  t = 6'd31;
      4'd3:  t = 6'd2;
      4'd4:  t = 6'd5;
      4'd5:  t = 6'd7;
      4'd6:  t = 6'd10;
      4'd7:  t = 6'd12;
      4'd8:  t = 6'd15;
      4'd9:  t = 6'd18;
      4'd10: t = 6'd20;
      4'd11: t = 6'd23;
      4'd12: t = 6'd25;
      4'd13: t = 6'd28;
      4'd14: t = 6'd31;
      4'd15: t = 6'd33;
      default: t = 6'd0;
    endcase
    return t;
  endfunction

endpackage

>>> sv/bdrd_day_step.sv
// Advances a date by one calendar day, with month, leap year and year saturation.
// Depends on bdrd_pkg for the date struct and the month length table.
module bdrd_day_step import bdrd_pkg::*; (
  input  date_st_t cur,
  output date_st_t nxt,
  output logic     sat
);

  logic             leap;
  logic [DAY_W-1:0] dim;

  // Year mod 4 equals the low bits of the year within its century.
  assign leap = (cur.yrem[1:0] == 2'd0) && ((cur.yrem != '0) || (cur.ycent[1:0] == 2'd0));
  assign dim  = month_days(cur.month, leap);

  always_comb begin
    nxt = cur;
    sat = 1'b0;
    priority if (cur.day == '0) begin
      nxt.day = DAY_W'(1);
    end else if (cur.day >= dim) begin
      nxt.day = DAY_W'(1);
      if (cur.month >= MONTH_DEC) begin
        if (cur.year >= YEAR_MAX) begin
          sat       = 1'b1;
          nxt.day   = DAY_LAST;
          nxt.month = MONTH_DEC;
          nxt.year  = YEAR_MAX;
        end else begin
          nxt.month = MONTH_W'(1);
          nxt.year  = cur.year + YEAR_W'(1);
          if (cur.yrem == YEARS_CENT - YREM_W'(1)) begin
            nxt.yrem  = '0;
            nxt.ycent = cur.ycent + YCENT_W'(1);
          end else begin
            nxt.yrem = cur.yrem + YREM_W'(1);
          end
        end
      end else begin
        nxt.month = cur.month + MONTH_W'(1);
      end
    end else begin
      nxt.day = cur.day + DAY_W'(1);
    end
    // The weekday stands still only when the date saturates.
    if (!sat) begin
      nxt.wd = (cur.wd == WD_SAT) ? '0 : cur.wd + WD_W'(1);
    end
  end

endmodule

>>> sv/business_day_return_date_top.sv
// Top level of the business day return date block: sequencer, shared subtract unit.
// Depends on bdrd_pkg and bdrd_day_step.
//
//   channel  direction  payload     handshake
//   in_      request    in_req_t    in_valid / in_stall
//   out_     result     out_rsp_t   out_valid / out_stall
//
// A request first splits the year by 100, then sums the weekday terms and reduces that
// sum mod 7, all on one shared subtract-compare unit.
// Then one calendar day is stepped per cycle until the result is ready.
// in_stall is high from acceptance until the result is loaded into the output register.
// Reset is synchronous and active low; no clearing pass is needed.
module business_day_return_date_top import bdrd_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output out_rsp_t out_data
);

  localparam int EXT_W = (COUNT_BITS > BDAYS_W) ? COUNT_BITS : BDAYS_W;

  bdrd_state_t             state_r, state_nxt;
  date_st_t                date_r, date_nxt;
  logic [COUNT_BITS-1:0]   left_r, left_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [DIVR_W-1:0]       rem_r, rem_nxt;
  logic [YCENT_W-1:0]      quo_r, quo_nxt;
  logic [3:0]              k_r, k_nxt;
  out_rsp_t                out_r, out_nxt;
  logic                    out_valid_r, out_valid_nxt;

  logic                    in_acc;
  logic                    load_out;
  logic                    weekend;
  date_st_t                step_date;
  logic                    step_sat;
  logic [EXT_W-1:0]        bd_ext;

  logic [TRIAL_W-1:0]      divisor;
  logic [TRIAL_W-1:0]      trial;
  logic                    trial_ge;

  logic                    a_adj;
  logic                    neg_yr;
  logic [YEAR_W-1:0]       yr_val;
  logic [YCENT_W-1:0]      qy;
  logic [15:0]             wsum;

  bdrd_day_step u_step (
    .cur (date_r),
    .nxt (step_date),
    .sat (step_sat)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign weekend   = (date_r.wd == WD_FRI) || (date_r.wd == WD_SAT);
  assign load_out  = (state_r == ST_FINISH) && (!out_valid_r || !out_stall);
  assign bd_ext    = EXT_W'(in_data.business_days);

  // Shared restoring-division step: divide by 100 for the year, by 7 for the weekday.
  assign divisor  = ((state_r == ST_MOD) ? TRIAL_W'(DIV_WEEK) : TRIAL_W'(DIV_YEAR)) << k_r;
  assign trial    = TRIAL_W'(rem_r) - divisor;
  assign trial_ge = (TRIAL_W'(rem_r) >= divisor);

  // Weekday sum; the shifted year is -1 only for year 0 in a month up to February.
  always_comb begin
    a_adj  = (date_r.month <= MONTH_FEB);
    neg_yr = a_adj && (date_r.year == '0);
    if (neg_yr) begin
      yr_val = '0;
      qy     = '0;
    end else begin
      yr_val = date_r.year - YEAR_W'(a_adj);
      qy     = (a_adj && (date_r.yrem == '0)) ? date_r.ycent - YCENT_W'(1) : date_r.ycent;
    end
    wsum = 16'(date_r.day) + 16'(yr_val) + 16'(yr_val >> 2) + 16'(mo_term(date_r.month))
         + 16'(qy >> 2) - 16'(qy) - 16'(neg_yr);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:   if (in_acc) state_nxt = ST_DIV;
      ST_DIV:    if (k_r == '0) state_nxt = ST_SUM;
      ST_SUM:    state_nxt = ST_MOD;
      ST_MOD:    if (k_r == '0) state_nxt = ST_SKIP1;
      ST_SKIP1: begin
        if (!weekend) state_nxt = ST_COUNT;
        else if (step_sat) state_nxt = ST_FINISH;
      end
      ST_COUNT: begin
        if (left_r == '0) state_nxt = ST_SKIP2;
        else if (step_sat) state_nxt = ST_FINISH;
      end
      ST_SKIP2: begin
        if (!weekend || step_sat) state_nxt = ST_FINISH;
      end
      ST_FINISH: if (load_out) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    date_nxt      = date_r;
    left_nxt      = left_r;
    ovf_nxt       = ovf_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    k_nxt         = k_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          date_nxt.day   = in_data.start_day;
          date_nxt.month = in_data.start_month;
          date_nxt.year  = in_data.start_year;
          date_nxt.wd    = '0;
          left_nxt       = bd_ext[COUNT_BITS-1:0];
          ovf_nxt        = 1'b0;
          rem_nxt        = DIVR_W'(in_data.start_year);
          quo_nxt        = '0;
          k_nxt          = DIV_TOP;
        end
      end
      ST_DIV: begin
        if (trial_ge) begin
          rem_nxt            = trial[DIVR_W-1:0];
          quo_nxt[k_r[2:0]]  = 1'b1;
        end
        if (k_r == '0) begin
          date_nxt.ycent = trial_ge ? quo_r | YCENT_W'(1) : quo_r;
          date_nxt.yrem  = trial_ge ? trial[YREM_W-1:0] : rem_r[YREM_W-1:0];
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_SUM: begin
        rem_nxt = wsum[DIVR_W-1:0];
        k_nxt   = MOD_TOP;
      end
      ST_MOD: begin
        if (trial_ge) begin
          rem_nxt = trial[DIVR_W-1:0];
        end
        if (k_r == '0) begin
          date_nxt.wd = trial_ge ? trial[WD_W-1:0] : rem_r[WD_W-1:0];
        end else begin
          k_nxt = k_r - 4'd1;
        end
      end
      ST_SKIP1, ST_SKIP2: begin
        if (weekend) begin
          date_nxt = step_date;
          ovf_nxt  = step_sat;
        end
      end
      ST_COUNT: begin
        if (left_r != '0) begin
          if (!weekend) left_nxt = left_r - COUNT_BITS'(1);
          date_nxt = step_date;
          ovf_nxt  = step_sat;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_nxt.end_day       = date_r.day;
          out_nxt.end_month     = date_r.month;
          out_nxt.end_year      = date_r.year;
          out_nxt.year_overflow = ovf_r;
          out_valid_nxt         = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      date_r      <= '0;
      left_r      <= '0;
      ovf_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      date_r      <= date_nxt;
      left_r      <= left_nxt;
      ovf_r       <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    k_r   <= k_nxt;
    out_r <= out_nxt;
  end

  a_acc_starts_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == ST_DIV)
    else $error("accepted request did not start the year division");

  a_yrem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SUM |-> date_r.yrem < YEARS_CENT)
    else $error("year remainder not below one hundred after division");

  a_wd_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SKIP1 || state_r == ST_COUNT || state_r == ST_SKIP2) |-> date_r.wd != 3'd7)
    else $error("weekday out of range while stepping");

  a_ovf_date: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FINISH && ovf_r) |->
      (date_r.year == YEAR_MAX && date_r.month == MONTH_DEC && date_r.day == DAY_LAST))
    else $error("overflow flagged without a saturated date");

  a_left_down: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COUNT && left_r != '0) |=> left_r <= $past(left_r))
    else $error("business day count grew while counting");

endmodule
